/* sv/spd_pkg.sv */
// shared constants, register codes and address helpers for the sequence period detector
// no dependencies
package spd_pkg;

	localparam int HIST_DEPTH = 64;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
	localparam int SYM_W      = 16;
	localparam int PAT_DEPTH  = 32;
	localparam int PAT_AW     = $clog2(PAT_DEPTH);
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_CYCLES = 2'd1;

	localparam logic CMD_OBSERVE = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	// oldest-entry slot of the circular history
	function automatic logic [HIST_AW-1:0] hist_base(input logic [HIST_AW-1:0] wptr,
	                                                 input logic [FILL_W-1:0] fill);
		logic [FILL_W:0] t;
		t = {2'b00, wptr} + (FILL_W+1)'(HIST_DEPTH) - {1'b0, fill};
		if (t >= (FILL_W+1)'(HIST_DEPTH)) t = t - (FILL_W+1)'(HIST_DEPTH);
		return t[HIST_AW-1:0];
	endfunction

	// physical slot of logical entry k (0 is oldest)
	function automatic logic [HIST_AW-1:0] hist_phys(input logic [HIST_AW-1:0] base,
	                                                 input logic [FILL_W-1:0] k);
		logic [FILL_W:0] t;
		t = {2'b00, base} + {1'b0, k};
		if (t >= (FILL_W+1)'(HIST_DEPTH)) t = t - (FILL_W+1)'(HIST_DEPTH);
		return t[HIST_AW-1:0];
	endfunction

endpackage

/* sv/spd_if.sv */
// valid/ready channel interfaces for symbol transactions and result transactions
// depends on spd_pkg
interface spd_req_if;
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [spd_pkg::SYM_W-1:0] symbol_id;
	modport source (output valid, output cmd, output symbol_id, input ready);
	modport sink   (input valid, input cmd, input symbol_id, output ready);
endinterface

interface spd_rsp_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic        locked;
	logic [5:0]  period;
	logic [31:0] transitions;
	modport source (output valid, output accepted, output locked, output period,
	                output transitions, input ready);
	modport sink   (input valid, input accepted, input locked, input period,
	                input transitions, output ready);
endinterface

/* sv/spd_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module spd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* sv/sequence_period_detector.sv */
// top level of the sequence period detector
// depends on spd_pkg, spd_if and spd_ram
//
// Symbol transactions enter on req one at a time; each gives one result transaction on rsp.
// A clear or a repeated symbol goes straight to the output state. A new symbol while locked
// is checked against the pattern (one pattern ram read). Otherwise the period search runs:
// for each candidate period p from min_period upward it streams p*(confirm_cycles-1)
// pairwise comparisons of history entries that lie p apart, one per cycle through two
// copies of the history ram, ending early at the first mismatch; on success the first p
// entries of the compared window are copied into the pattern ram.
// No clearing pass after reset.
module sequence_period_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [spd_pkg::CFG_W-1:0]      cfg_data,
	spd_req_if.sink                        req,
	spd_rsp_if.source                      rsp
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PCHK = 3'd1;
	localparam logic [2:0] ST_SP   = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_COPY = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;

	// configuration
	logic [spd_pkg::CFG_W-1:0] min_period_q, confirm_q;
	logic [6:0] mp_eff, cc_eff;

	// tracking state
	logic [spd_pkg::SYM_W-1:0]   prev_sym_q, sym_q;
	logic                        prev_valid_q;
	logic [spd_pkg::HIST_AW-1:0] wptr_q;
	logic [spd_pkg::FILL_W-1:0]  fill_q;
	logic [5:0]                  len_q;
	logic [spd_pkg::PAT_AW-1:0]  pos_q;
	logic                        lock_q;
	logic [31:0]                 count_q;
	logic                        acc_q;

	// search state
	logic [6:0]                  p_q;
	logic [spd_pkg::FILL_W-1:0]  start_q, j_q;
	logic [5:0]                  i_q;
	logic                        rd_v_s1, cp_v_s1;
	logic [spd_pkg::PAT_AW-1:0]  cpi_s1;

	// output register
	logic        out_valid_q, out_acc_q, out_lock_q;
	logic [5:0]  out_period_q;
	logic [31:0] out_trans_q;

	logic accept, repeat_sym, out_load;
	logic [13:0] prod;
	logic [spd_pkg::HIST_AW-1:0] base, ha_raddr, hb_raddr;
	logic [spd_pkg::SYM_W-1:0]   ha_data, hb_data, pat_data;
	logic [spd_pkg::FILL_W-1:0]  j_back, copy_k;
	logic                        hist_we;

	assign mp_eff = (min_period_q == '0) ? 7'd1 : min_period_q;
	assign cc_eff = (confirm_q < 7'd2) ? 7'd2 : confirm_q;
	assign prod   = {7'b0, p_q} * {7'b0, cc_eff};

	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign repeat_sym = prev_valid_q && (prev_sym_q == req.symbol_id);
	assign hist_we    = accept && (req.cmd == spd_pkg::CMD_OBSERVE) && !repeat_sym;
	// result moves into the output register once that is free
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);

	// history addresses: scan compares entry j with entry j-p, copy reads start+i
	assign base   = spd_pkg::hist_base(wptr_q, fill_q);
	assign j_back = j_q - p_q[spd_pkg::FILL_W-1:0];
	assign copy_k = start_q + spd_pkg::FILL_W'(i_q);

	always_comb begin
		ha_raddr = spd_pkg::hist_phys(base, j_q);
		hb_raddr = spd_pkg::hist_phys(base, j_back);
		if (state_q == ST_COPY) ha_raddr = spd_pkg::hist_phys(base, copy_k);
	end

	spd_ram #(.WIDTH(spd_pkg::SYM_W), .DEPTH(spd_pkg::HIST_DEPTH)) u_hist_a (
		.clk(clk), .we(hist_we), .waddr(wptr_q), .wdata(req.symbol_id),
		.raddr(ha_raddr), .rdata(ha_data)
	);
	spd_ram #(.WIDTH(spd_pkg::SYM_W), .DEPTH(spd_pkg::HIST_DEPTH)) u_hist_b (
		.clk(clk), .we(hist_we), .waddr(wptr_q), .wdata(req.symbol_id),
		.raddr(hb_raddr), .rdata(hb_data)
	);
	spd_ram #(.WIDTH(spd_pkg::SYM_W), .DEPTH(spd_pkg::PAT_DEPTH)) u_pat (
		.clk(clk), .we(cp_v_s1), .waddr(cpi_s1), .wdata(ha_data),
		.raddr(pos_q), .rdata(pat_data)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= 7'd1;
			confirm_q    <= 7'd2;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				spd_pkg::REG_MIN_PERIOD:     min_period_q <= cfg_data;
				spd_pkg::REG_CONFIRM_CYCLES: confirm_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_sym_q   <= '0;
			prev_valid_q <= 1'b0;
			wptr_q       <= '0;
			fill_q       <= '0;
			len_q        <= '0;
			pos_q        <= '0;
			lock_q       <= 1'b0;
			count_q      <= '0;
			acc_q        <= 1'b0;
			rd_v_s1      <= 1'b0;
			cp_v_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (rsp.ready && !out_load) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.cmd == spd_pkg::CMD_CLEAR) begin
							acc_q        <= 1'b0;
							prev_sym_q   <= '0;
							prev_valid_q <= 1'b0;
							wptr_q       <= '0;
							fill_q       <= '0;
							len_q        <= '0;
							pos_q        <= '0;
							lock_q       <= 1'b0;
							count_q      <= '0;
							state_q      <= ST_OUT;
						end else if (repeat_sym) begin
							acc_q   <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							// record the new symbol
							acc_q        <= 1'b1;
							sym_q        <= req.symbol_id;
							prev_sym_q   <= req.symbol_id;
							prev_valid_q <= 1'b1;
							if (count_q != 32'hFFFF_FFFF) count_q <= count_q + 32'd1;
							wptr_q <= (wptr_q == spd_pkg::HIST_AW'(spd_pkg::HIST_DEPTH - 1)) ?
							          '0 : wptr_q + 1'b1;
							if (fill_q != spd_pkg::FILL_W'(spd_pkg::HIST_DEPTH))
								fill_q <= fill_q + 1'b1;
							p_q     <= mp_eff;
							state_q <= lock_q ? ST_PCHK : ST_SP;
						end
					end
				end
				ST_PCHK: begin
					if (pat_data == sym_q) begin
						pos_q   <= (6'(pos_q) + 6'd1 >= len_q) ? '0 : pos_q + 1'b1;
						state_q <= ST_OUT;
					end else begin
						// mismatch drops the lock and searches again
						lock_q  <= 1'b0;
						len_q   <= '0;
						pos_q   <= '0;
						state_q <= ST_SP;
					end
				end
				ST_SP: begin
					if (p_q > 7'(spd_pkg::PAT_DEPTH) || prod > 14'(fill_q)) begin
						state_q <= ST_OUT;
					end else begin
						start_q <= fill_q - prod[spd_pkg::FILL_W-1:0];
						j_q     <= fill_q - prod[spd_pkg::FILL_W-1:0] +
						           p_q[spd_pkg::FILL_W-1:0];
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_v_s1 && ha_data != hb_data) begin
						p_q     <= p_q + 7'd1;
						rd_v_s1 <= 1'b0;
						state_q <= ST_SP;
					end else if (j_q < fill_q) begin
						j_q     <= j_q + 1'b1;
						rd_v_s1 <= 1'b1;
					end else if (!rd_v_s1) begin
						i_q     <= '0;
						state_q <= ST_COPY;
					end else begin
						rd_v_s1 <= 1'b0;
					end
				end
				ST_COPY: begin
					if (7'(i_q) < p_q) begin
						cpi_s1  <= i_q[spd_pkg::PAT_AW-1:0];
						cp_v_s1 <= 1'b1;
						i_q     <= i_q + 6'd1;
					end else begin
						cp_v_s1 <= 1'b0;
						if (!cp_v_s1) begin
							lock_q  <= 1'b1;
							len_q   <= p_q[5:0];
							pos_q   <= '0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					// hand the result to the output register once it is free
					if (out_load) begin
						out_valid_q  <= 1'b1;
						out_acc_q    <= acc_q;
						out_lock_q   <= lock_q;
						out_period_q <= lock_q ? len_q : 6'd0;
						out_trans_q  <= count_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.accepted    = out_acc_q;
	assign rsp.locked      = out_lock_q;
	assign rsp.period      = out_period_q;
	assign rsp.transitions = out_trans_q;
endmodule
